// ===== rtl/assert_macros.svh =====
// Assertion macros for the block's RTL files; rpf_back is the file that includes them.
// Each macro expects a clock i_clk and an active-low reset i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define RPF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// A condition that must be followed in the next cycle by another.
`define RPF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rpf_pkg.sv =====
// Package for the region max pooling block: sizes, register indexes and types.
// Used by every module of the block; depends on nothing.
package rpf_pkg;

    localparam int MAX_HEIGHT   = 32;
    localparam int MAX_WIDTH    = 32;
    localparam int MAX_CHANNELS = 16;
    localparam int MAX_IMAGES   = 2;
    localparam int MAX_BINS     = 8;

    localparam int ADDR_W  = 15;
    localparam int VAL_W   = 16;
    localparam int IDX_W   = 15;
    localparam int LI_W    = 14;
    localparam int COORD_W = 17;
    localparam int NUM_W   = 21;
    localparam int DIM_W   = 6;
    localparam int CH_W    = 5;
    localparam int BIN_W   = 4;
    localparam int DEPTH   = MAX_IMAGES * MAX_HEIGHT * MAX_WIDTH * MAX_CHANNELS;

    typedef enum logic [2:0] {
        REG_SCALE  = 3'd0,
        REG_CLASS  = 3'd1,
        REG_HEIGHT = 3'd2,
        REG_WIDTH  = 3'd3,
        REG_CHANS  = 3'd4,
        REG_BH     = 3'd5,
        REG_BW     = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [15:0]      scale;
        logic             by_class;
        logic [DIM_W-1:0] h;
        logic [DIM_W-1:0] w;
        logic [CH_W-1:0]  c;
        logic [BIN_W-1:0] bh;
        logic [BIN_W-1:0] bw;
    } t_cfg;

    typedef struct packed {
        logic               is_pool;
        logic [ADDR_W-1:0]  addr;
        logic [VAL_W-1:0]   value;
        logic               img;
        logic [3:0]         ch;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] rw;
        logic [COORD_W-1:0] rh;
    } t_cmd;

endpackage

// ===== rtl/rpf_front.sv =====
// Front part: registers each input beat, scales region corners, picks the channel.
// Depends on rpf_pkg; feeds rpf_fifo.
module rpf_front
    import rpf_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic         i_func,
    input  logic [14:0]  i_feat_addr,
    input  logic [15:0]  i_feat_value,
    input  logic         i_roi_image,
    input  logic [3:0]   i_roi_class,
    input  logic [11:0]  i_roi_x1,
    input  logic [11:0]  i_roi_y1,
    input  logic [11:0]  i_roi_x2,
    input  logic [11:0]  i_roi_y2,
    input  logic [3:0]   i_pool_chan,
    input  logic         i_q_full,
    output logic         o_push,
    output t_cmd         o_cmd
);

    logic               r_valid;
    logic               r_func;
    logic [14:0]        r_addr;
    logic [15:0]        r_value;
    logic               r_img;
    logic [3:0]         r_class;
    logic [3:0]         r_chan;
    logic [11:0]        r_x1, r_y1, r_x2, r_y2;
    logic [3:0]         sel;
    logic [COORD_W-1:0] sx, sy, ex, ey;

    function automatic logic [COORD_W-1:0] scale_c(input logic [11:0] c,
                                                    input logic [15:0] s);
        logic [28:0] p;
        p = 29'(c) * 29'(s) + 29'd2048;
        return p[28:12];
    endfunction

    assign o_stall = r_valid && i_q_full;
    assign o_push  = r_valid && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
        if (!o_stall) begin
            r_func  <= i_func;
            r_addr  <= i_feat_addr;
            r_value <= i_feat_value;
            r_img   <= i_roi_image;
            r_class <= i_roi_class;
            r_chan  <= i_pool_chan;
            r_x1    <= i_roi_x1;
            r_y1    <= i_roi_y1;
            r_x2    <= i_roi_x2;
            r_y2    <= i_roi_y2;
        end
    end

    always_comb begin
        sel = i_cfg.by_class ? r_class : r_chan;
        if ({1'b0, sel} >= i_cfg.c) begin
            sel = 4'(i_cfg.c - 5'd1);
        end
        sx = scale_c(r_x1, i_cfg.scale);
        sy = scale_c(r_y1, i_cfg.scale);
        ex = scale_c(r_x2, i_cfg.scale);
        ey = scale_c(r_y2, i_cfg.scale);
        o_cmd.is_pool = r_func;
        o_cmd.addr    = r_addr;
        o_cmd.value   = r_value;
        o_cmd.img     = r_img;
        o_cmd.ch      = sel;
        o_cmd.sx      = sx;
        o_cmd.sy      = sy;
        o_cmd.rw      = (ex < sx) ? COORD_W'(1) : ex - sx + COORD_W'(1);
        o_cmd.rh      = (ey < sy) ? COORD_W'(1) : ey - sy + COORD_W'(1);
    end

endmodule

// ===== rtl/rpf_fifo.sv =====
// Two-entry command queue between the front and back parts.
// Depends on rpf_pkg for the command type.
module rpf_fifo
    import rpf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/rpf_div.sv =====
// Restoring divider, one quotient bit per cycle, for the bin bound arithmetic.
// Depends on rpf_pkg for the dividend width.
module rpf_div
    import rpf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [BIN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    logic [NUM_W-1:0] r_num;
    logic [BIN_W-1:0] r_den;
    logic [BIN_W-1:0] r_rem;
    logic [4:0]       r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [BIN_W:0]   rem_sh;
    logic             take;

    assign rem_sh = {r_rem, r_num[NUM_W-1]};
    assign take   = (rem_sh >= {1'b0, r_den});
    assign o_done = r_done;
    assign o_quot = r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= take ? BIN_W'(rem_sh - {1'b0, r_den}) : rem_sh[BIN_W-1:0];
            r_num <= {r_num[NUM_W-2:0], take};
        end
    end

endmodule

// ===== rtl/rpf_back.sv =====
// Back part: holds the feature store, works out bin bounds and scans each bin.
// Depends on rpf_pkg, rpf_div and assert_macros.svh.
`include "assert_macros.svh"
module rpf_back
    import rpf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_q_valid,
    input  t_cmd             i_cmd,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [VAL_W-1:0] o_pooled_value,
    output logic [IDX_W-1:0] o_max_index,
    output logic [2:0]       o_bin_row,
    output logic [2:0]       o_bin_col,
    output logic             o_last_bin
);

    typedef enum logic [3:0] {
        S_IDLE, S_HW, S_HWC, S_BIN, S_DIV_ISSUE, S_DIV_WAIT, S_CLIP,
        S_ROW, S_LI, S_READ, S_CMP, S_EMIT
    } t_state;

    logic [VAL_W-1:0]   mem [DEPTH];
    logic [VAL_W-1:0]   r_rd;
    t_state             r_state;
    t_cmd               r_cmd;
    logic [10:0]        r_hw;
    logic [ADDR_W-1:0]  r_base;
    logic [2:0]         r_ph, r_pw;
    logic [1:0]         r_dsel;
    logic [NUM_W-1:0]   r_q [4];
    logic [DIM_W-1:0]   r_h, r_w, r_ws, r_he, r_we;
    logic [9:0]         r_t;
    logic [LI_W-1:0]    r_li;
    logic               r_have;
    logic [VAL_W-1:0]   r_best;
    logic [IDX_W-1:0]   r_bidx;
    logic               r_out_valid;
    logic [VAL_W-1:0]   r_out_val;
    logic [IDX_W-1:0]   r_out_idx;
    logic [2:0]         r_out_row, r_out_col;
    logic               r_out_last;
    logic               div_start;
    logic               div_done;
    logic [NUM_W-1:0]   div_quot;
    logic [NUM_W-1:0]   n_num;
    logic [BIN_W-1:0]   n_den;
    logic [BIN_W-1:0]   ph1, pw1;
    logic [DIM_W-1:0]   n_hs, n_he, n_ws, n_we;
    logic [ADDR_W-1:0]  rd_addr;
    logic               last_col, last_row;

    function automatic logic [DIM_W-1:0] clip(input logic [NUM_W-1:0] q,
                                              input logic [COORD_W-1:0] s,
                                              input logic [DIM_W-1:0] lim);
        logic [NUM_W:0] sum;
        sum = {1'b0, q} + (NUM_W+1)'(s);
        return (sum > (NUM_W+1)'(lim)) ? lim : sum[DIM_W-1:0];
    endfunction

    rpf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (n_num),
        .i_den   (n_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_pop     = (r_state == S_IDLE) && i_q_valid;
    assign div_start = (r_state == S_DIV_ISSUE);
    assign ph1       = {1'b0, r_ph} + BIN_W'(1);
    assign pw1       = {1'b0, r_pw} + BIN_W'(1);
    assign rd_addr   = r_base + ADDR_W'(r_li);
    assign last_col  = ({1'b0, r_pw} == i_cfg.bw - BIN_W'(1));
    assign last_row  = ({1'b0, r_ph} == i_cfg.bh - BIN_W'(1));

    always_comb begin
        case (r_dsel)
            2'd0: begin
                n_num = NUM_W'(r_ph) * NUM_W'(r_cmd.rh);
                n_den = i_cfg.bh;
            end
            2'd1: begin
                n_num = NUM_W'(ph1) * NUM_W'(r_cmd.rh) + NUM_W'(i_cfg.bh) - NUM_W'(1);
                n_den = i_cfg.bh;
            end
            2'd2: begin
                n_num = NUM_W'(r_pw) * NUM_W'(r_cmd.rw);
                n_den = i_cfg.bw;
            end
            default: begin
                n_num = NUM_W'(pw1) * NUM_W'(r_cmd.rw) + NUM_W'(i_cfg.bw) - NUM_W'(1);
                n_den = i_cfg.bw;
            end
        endcase
        n_hs = clip(r_q[0], r_cmd.sy, i_cfg.h);
        n_he = clip(r_q[1], r_cmd.sy, i_cfg.h);
        n_ws = clip(r_q[2], r_cmd.sx, i_cfg.w);
        n_we = clip(r_q[3], r_cmd.sx, i_cfg.w);
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && !i_cmd.is_pool) begin
            mem[i_cmd.addr] <= i_cmd.value;
        end
        if (r_state == S_READ) begin
            r_rd <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_cmd <= i_cmd;
                        if (i_cmd.is_pool) begin
                            r_state <= S_HW;
                        end
                    end
                end
                S_HW: begin
                    r_hw    <= 11'(i_cfg.h) * 11'(i_cfg.w);
                    r_ph    <= '0;
                    r_pw    <= '0;
                    r_state <= S_HWC;
                end
                S_HWC: begin
                    r_base  <= r_cmd.img ? ADDR_W'(r_hw) * ADDR_W'(i_cfg.c) : '0;
                    r_state <= S_BIN;
                end
                S_BIN: begin
                    r_dsel  <= '0;
                    r_state <= S_DIV_ISSUE;
                end
                S_DIV_ISSUE: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        r_q[r_dsel] <= div_quot;
                        r_dsel      <= r_dsel + 2'd1;
                        r_state     <= (r_dsel == 2'd3) ? S_CLIP : S_DIV_ISSUE;
                    end
                end
                S_CLIP: begin
                    r_h    <= n_hs;
                    r_w    <= n_ws;
                    r_ws   <= n_ws;
                    r_he   <= n_he;
                    r_we   <= n_we;
                    r_have <= 1'b0;
                    r_best <= '0;
                    r_bidx <= '1;
                    r_state <= (n_hs >= n_he || n_ws >= n_we) ? S_EMIT : S_ROW;
                end
                S_ROW: begin
                    r_t     <= 10'(r_h) * 10'(i_cfg.w) + 10'(r_w);
                    r_state <= S_LI;
                end
                S_LI: begin
                    r_li    <= LI_W'(r_t) * LI_W'(i_cfg.c) + LI_W'(r_cmd.ch);
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (!r_have || $signed(r_rd) > $signed(r_best)) begin
                        r_best <= r_rd;
                        r_bidx <= IDX_W'(r_li);
                        r_have <= 1'b1;
                    end
                    if (r_w + DIM_W'(1) < r_we) begin
                        r_w     <= r_w + DIM_W'(1);
                        r_li    <= r_li + LI_W'(i_cfg.c);
                        r_state <= S_READ;
                    end else if (r_h + DIM_W'(1) < r_he) begin
                        r_h     <= r_h + DIM_W'(1);
                        r_w     <= r_ws;
                        r_state <= S_ROW;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_val   <= r_best;
                        r_out_idx   <= r_bidx;
                        r_out_row   <= r_ph;
                        r_out_col   <= r_pw;
                        r_out_last  <= last_row && last_col;
                        if (last_col) begin
                            r_pw    <= '0;
                            r_ph    <= r_ph + 3'd1;
                            r_state <= last_row ? S_IDLE : S_BIN;
                        end else begin
                            r_pw    <= r_pw + 3'd1;
                            r_state <= S_BIN;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_pooled_value = r_out_val;
    assign o_max_index    = r_out_idx;
    assign o_bin_row      = r_out_row;
    assign o_bin_col      = r_out_col;
    assign o_last_bin     = r_out_last;

    `RPF_ASSERT(a_scan_in_bin, (r_state == S_READ) |-> (r_h < r_he && r_w < r_we), "scan outside bin")
    `RPF_ASSERT(a_pop_idle, o_pop |-> (r_state == S_IDLE), "queue popped while busy")
    `RPF_ASSERT(a_empty_zero, (r_out_valid && r_out_idx == '1) |-> (r_out_val == '0), "empty bin not zero")
    `RPF_ASSERT_NEXT(a_div_wait, r_state == S_DIV_ISSUE, r_state == S_DIV_WAIT, "divider not awaited")

endmodule

// ===== rtl/roi_max_pool_forward.sv =====
// Channel    | Handshake          | Beat contents
// input      | i_valid / o_stall  | load (address, value) or pool (region, class, channel)
// output     | o_valid / i_stall  | one bin: maximum, index, row, column, last flag
// config     | i_cfg_we           | register index and data, no handshake back
// A load beat passes the front register and the queue, and is written to the store when the back part pops it.
// A pool beat runs set-up (S_HW, S_HWC), then per bin S_BIN, four serial divisions,
// S_CLIP, a scan (S_ROW, S_LI per row; S_READ, S_CMP per element) and S_EMIT.
// The feature store is one single-port memory, read once per scanned element.
// Reset clears control state only; store contents are undefined until loaded.
// A stalled output holds its bin; the two-entry queue lets loads arrive meanwhile.
module roi_max_pool_forward
    import rpf_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic         i_func,
    input  logic [14:0]  i_feat_addr,
    input  logic [15:0]  i_feat_value,
    input  logic         i_roi_image,
    input  logic [3:0]   i_roi_class,
    input  logic [11:0]  i_roi_x1,
    input  logic [11:0]  i_roi_y1,
    input  logic [11:0]  i_roi_x2,
    input  logic [11:0]  i_roi_y2,
    input  logic [3:0]   i_pool_chan,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [15:0]  o_pooled_value,
    output logic [14:0]  o_max_index,
    output logic [2:0]   o_bin_row,
    output logic [2:0]   o_bin_col,
    output logic         o_last_bin
);

    logic [15:0] r_scale;
    logic        r_class;
    logic [5:0]  r_h, r_w;
    logic [4:0]  r_c;
    logic [3:0]  r_bh, r_bw;
    t_cfg        cfg;
    logic        push, pop, q_full, q_valid;
    t_cmd        f_cmd, b_cmd;

    function automatic logic [7:0] sat(input logic [7:0] v, input logic [7:0] hi);
        if (v == 8'd0) begin
            return 8'd1;
        end
        return (v > hi) ? hi : v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= 16'd256;
            r_class <= 1'b0;
            r_h     <= 6'd32;
            r_w     <= 6'd32;
            r_c     <= 5'd16;
            r_bh    <= 4'd7;
            r_bw    <= 4'd7;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_SCALE:  r_scale <= i_cfg_data;
                REG_CLASS:  r_class <= i_cfg_data[0];
                REG_HEIGHT: r_h     <= i_cfg_data[5:0];
                REG_WIDTH:  r_w     <= i_cfg_data[5:0];
                REG_CHANS:  r_c     <= i_cfg_data[4:0];
                REG_BH:     r_bh    <= i_cfg_data[3:0];
                REG_BW:     r_bw    <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.scale    = r_scale;
        cfg.by_class = r_class;
        cfg.h  = DIM_W'(sat(8'(r_h), 8'(MAX_HEIGHT)));
        cfg.w  = DIM_W'(sat(8'(r_w), 8'(MAX_WIDTH)));
        cfg.c  = CH_W'(sat(8'(r_c), 8'(MAX_CHANNELS)));
        cfg.bh = BIN_W'(sat(8'(r_bh), 8'(MAX_BINS)));
        cfg.bw = BIN_W'(sat(8'(r_bw), 8'(MAX_BINS)));
    end

    rpf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_feat_addr  (i_feat_addr),
        .i_feat_value (i_feat_value),
        .i_roi_image  (i_roi_image),
        .i_roi_class  (i_roi_class),
        .i_roi_x1     (i_roi_x1),
        .i_roi_y1     (i_roi_y1),
        .i_roi_x2     (i_roi_x2),
        .i_roi_y2     (i_roi_y2),
        .i_pool_chan  (i_pool_chan),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_cmd        (f_cmd)
    );

    rpf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_cmd   (b_cmd)
    );

    rpf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_q_valid      (q_valid),
        .i_cmd          (b_cmd),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pooled_value (o_pooled_value),
        .o_max_index    (o_max_index),
        .o_bin_row      (o_bin_row),
        .o_bin_col      (o_bin_col),
        .o_last_bin     (o_last_bin)
    );

endmodule
